### src/utc_to_local_datetime_assert.svh
// Assertion macros used by the port checker file.
`ifndef UTC_TO_LOCAL_DATETIME_ASSERT_SVH
`define UTC_TO_LOCAL_DATETIME_ASSERT_SVH

// Checked only while out of reset.
`define UTCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define UTCL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/utcl_pkg.sv
`timescale 1ns / 1ps

package utcl_pkg;

    localparam logic [1:0] CFG_IDX_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_IDX_YEAR_MIN = 2'd1;
    localparam logic [1:0] CFG_IDX_YEAR_MAX = 2'd2;

    localparam logic signed [16:0] OFFSET_RST   = -17'sd10800;
    localparam logic [11:0]        YEAR_MIN_RST = 12'd2024;
    localparam logic [11:0]        YEAR_MAX_RST = 12'd2099;

    localparam logic [16:0]        SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0]        SECS_PER_MIN  = 17'd60;
    localparam logic signed [18:0] SECS_PER_DAY  = 19'sd86400;

    // floor(x / 3600) for x < 86400: (x * 1165) >> 22 is exact or one low
    localparam logic [26:0] HOUR_RECIP = 27'd1165;
    localparam int          HOUR_SHIFT = 22;
    // floor(x / 60) for x < 3600: (x * 1092) >> 16 is exact or one low
    localparam logic [21:0] MIN_RECIP  = 22'd1092;
    localparam int          MIN_SHIFT  = 16;
    // floor(y / 25) for y < 4096, exact
    localparam logic [24:0] Y25_RECIP  = 25'd5243;
    localparam int          Y25_SHIFT  = 17;

    typedef struct packed {
        logic       ok;
        logic [4:0] dim_cur;
        logic [4:0] dim_prev;
    } utcl_chk_t;

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } utcl_date_t;

    function automatic logic [4:0] month_days(logic [3:0] month, logic leap_yr);
        logic [4:0] d;
        case (month) inside
            4'd2:                    d = leap_yr ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

### src/utc_to_local_datetime.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_utc_year .. s_utc_second
// m_        out        m_valid / m_ready  m_valid_res, m_local_* fields
// cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
// Seven register stages: check, offset add, day rollover, hour estimate,
// hour fix, minute estimate, minute fix into the output register.
// One transfer per cycle in and out while the output is not stalled.
// Each stage holds while its successor is full and stalled, so bubbles
// close up and nothing is lost or repeated. aresetn is synchronous and
// clears stage valids and loads the register reset values.

module utc_to_local_datetime
    import utcl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_utc_year,
    input  logic [3:0]  s_utc_month,
    input  logic [4:0]  s_utc_day,
    input  logic [4:0]  s_utc_hour,
    input  logic [5:0]  s_utc_minute,
    input  logic [5:0]  s_utc_second,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [12:0] m_local_year,
    output logic [3:0]  m_local_month,
    output logic [4:0]  m_local_day,
    output logic [4:0]  m_local_hour,
    output logic [5:0]  m_local_minute,
    output logic [5:0]  m_local_second,
    output logic [16:0] m_local_seconds_of_day
);

    logic signed [16:0] offset_reg;
    logic [11:0]        year_min_reg;
    logic [11:0]        year_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= OFFSET_RST;
            year_min_reg <= YEAR_MIN_RST;
            year_max_reg <= YEAR_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IDX_OFFSET:   offset_reg   <= $signed(cfg_wdata);
                CFG_IDX_YEAR_MIN: year_min_reg <= cfg_wdata[11:0];
                CFG_IDX_YEAR_MAX: year_max_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // stage valids and advance enables
    logic [7:1] vld_reg;
    logic [8:1] adv;

    always_comb begin
        adv[8] = m_ready;
        for (int i = 7; i >= 1; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= s_valid;
            end
            for (int i = 2; i <= 7; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_ready = adv[1];
    assign m_valid = vld_reg[7];

    // stage 1: checks and UTC seconds of day
    utcl_chk_t chk;

    utcl_date_check u_date_check (
        .year     (s_utc_year),
        .month    (s_utc_month),
        .day      (s_utc_day),
        .hour     (s_utc_hour),
        .minute   (s_utc_minute),
        .second   (s_utc_second),
        .year_min (year_min_reg),
        .year_max (year_max_reg),
        .chk      (chk)
    );

    logic [16:0] sod_next;
    logic        ok1_reg;
    logic [16:0] sod1_reg;
    logic [11:0] year1_reg;
    logic [3:0]  month1_reg;
    logic [4:0]  day1_reg;
    logic [4:0]  dcur1_reg;
    logic [4:0]  dprev1_reg;

    assign sod_next = 17'(s_utc_hour) * SECS_PER_HOUR + 17'(s_utc_minute) * SECS_PER_MIN
                    + 17'(s_utc_second);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            ok1_reg    <= chk.ok;
            sod1_reg   <= sod_next;
            year1_reg  <= s_utc_year;
            month1_reg <= s_utc_month;
            day1_reg   <= s_utc_day;
            dcur1_reg  <= chk.dim_cur;
            dprev1_reg <= chk.dim_prev;
        end
    end

    // stage 2: add offset
    logic               ok2_reg;
    logic signed [18:0] sum2_reg;
    logic [11:0]        year2_reg;
    logic [3:0]         month2_reg;
    logic [4:0]         day2_reg;
    logic [4:0]         dcur2_reg;
    logic [4:0]         dprev2_reg;

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            ok2_reg    <= ok1_reg;
            sum2_reg   <= $signed({2'b00, sod1_reg})
                        + $signed({{2{offset_reg[16]}}, offset_reg});
            year2_reg  <= year1_reg;
            month2_reg <= month1_reg;
            day2_reg   <= day1_reg;
            dcur2_reg  <= dcur1_reg;
            dprev2_reg <= dprev1_reg;
        end
    end

    // stage 3: bring time into one day, roll date
    logic               under;
    logic               over;
    logic signed [18:0] t_adj;
    utcl_date_t         date_next;
    logic [12:0]        year_ext;

    assign under    = sum2_reg < 19'sd0;
    assign over     = sum2_reg >= SECS_PER_DAY;
    assign year_ext = {1'b0, year2_reg};

    always_comb begin
        t_adj     = sum2_reg;
        date_next = '{year: year_ext, month: month2_reg, day: day2_reg};
        if (under) begin
            t_adj = sum2_reg + SECS_PER_DAY;
            if (day2_reg > 5'd1) begin
                date_next.day = day2_reg - 5'd1;
            end else if (month2_reg > 4'd1) begin
                date_next.month = month2_reg - 4'd1;
                date_next.day   = dprev2_reg;
            end else begin
                date_next.month = 4'd12;
                date_next.year  = year_ext - 13'd1;
                date_next.day   = dprev2_reg;
            end
        end else if (over) begin
            t_adj = sum2_reg - SECS_PER_DAY;
            if (day2_reg < dcur2_reg) begin
                date_next.day = day2_reg + 5'd1;
            end else if (month2_reg < 4'd12) begin
                date_next.day   = 5'd1;
                date_next.month = month2_reg + 4'd1;
            end else begin
                date_next.day   = 5'd1;
                date_next.month = 4'd1;
                date_next.year  = year_ext + 13'd1;
            end
        end
    end

    logic        ok3_reg;
    logic [16:0] t3_reg;
    utcl_date_t  date3_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            ok3_reg   <= ok2_reg;
            t3_reg    <= t_adj[16:0];
            date3_reg <= date_next;
        end
    end

    // stage 4: hour estimate
    logic [26:0] hprod;
    logic        ok4_reg;
    logic [16:0] t4_reg;
    logic [4:0]  hq4_reg;
    utcl_date_t  date4_reg;

    assign hprod = 27'(t3_reg) * HOUR_RECIP;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            ok4_reg   <= ok3_reg;
            t4_reg    <= t3_reg;
            hq4_reg   <= hprod[HOUR_SHIFT +: 5];
            date4_reg <= date3_reg;
        end
    end

    // stage 5: hour fix, seconds within hour
    logic [16:0] hrem;
    logic        hfix;
    logic        ok5_reg;
    logic [16:0] t5_reg;
    logic [4:0]  hour5_reg;
    logic [11:0] r5_reg;
    utcl_date_t  date5_reg;

    assign hrem = t4_reg - 17'(hq4_reg) * SECS_PER_HOUR;
    assign hfix = hrem >= SECS_PER_HOUR;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            ok5_reg   <= ok4_reg;
            t5_reg    <= t4_reg;
            hour5_reg <= hq4_reg + 5'(hfix);
            r5_reg    <= hfix ? 12'(hrem - SECS_PER_HOUR) : hrem[11:0];
            date5_reg <= date4_reg;
        end
    end

    // stage 6: minute estimate
    logic [21:0] mprod;
    logic        ok6_reg;
    logic [16:0] t6_reg;
    logic [4:0]  hour6_reg;
    logic [11:0] r6_reg;
    logic [5:0]  mq6_reg;
    utcl_date_t  date6_reg;

    assign mprod = 22'(r5_reg) * MIN_RECIP;

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            ok6_reg   <= ok5_reg;
            t6_reg    <= t5_reg;
            hour6_reg <= hour5_reg;
            r6_reg    <= r5_reg;
            mq6_reg   <= mprod[MIN_SHIFT +: 6];
            date6_reg <= date5_reg;
        end
    end

    // stage 7: minute fix into output register
    logic [11:0] mrem;
    logic        mfix;

    assign mrem = r6_reg - 12'(mq6_reg) * 12'(SECS_PER_MIN);
    assign mfix = mrem >= 12'(SECS_PER_MIN);

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            if (ok6_reg) begin
                m_valid_res            <= 1'b1;
                m_local_year           <= date6_reg.year;
                m_local_month          <= date6_reg.month;
                m_local_day            <= date6_reg.day;
                m_local_hour           <= hour6_reg;
                m_local_minute         <= mq6_reg + 6'(mfix);
                m_local_second         <= mfix ? 6'(mrem - 12'(SECS_PER_MIN)) : mrem[5:0];
                m_local_seconds_of_day <= t6_reg;
            end else begin
                m_valid_res            <= 1'b0;
                m_local_year           <= '0;
                m_local_month          <= '0;
                m_local_day            <= '0;
                m_local_hour           <= '0;
                m_local_minute         <= '0;
                m_local_second         <= '0;
                m_local_seconds_of_day <= '0;
            end
        end
    end

endmodule

### src/utcl_date_check.sv
`timescale 1ns / 1ps

module utcl_date_check
    import utcl_pkg::*;
(
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [11:0] year_min,
    input  logic [11:0] year_max,
    output utcl_chk_t   chk
);

    logic [24:0] y25_prod;
    logic [7:0]  y25_q;
    logic [11:0] y25_rem;
    logic        div25;
    logic        leap_yr;
    logic        year_ok;
    logic        month_ok;
    logic        day_ok;
    logic        time_ok;
    logic [4:0]  dim_cur;

    assign y25_prod = 25'(year) * Y25_RECIP;
    assign y25_q    = y25_prod[Y25_SHIFT +: 8];
    assign y25_rem  = year - 12'((12'(y25_q) << 4) + (12'(y25_q) << 3) + 12'(y25_q));
    assign div25    = (y25_rem == 12'd0);

    // div by 100 = div by 4 and 25; div by 400 = div by 16 and 25
    assign leap_yr  = (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));

    assign dim_cur  = month_days(month, leap_yr);
    assign year_ok  = (year >= year_min) && (year <= year_max);
    assign month_ok = (month >= 4'd1) && (month <= 4'd12);
    assign day_ok   = (day >= 5'd1) && (day <= dim_cur);
    assign time_ok  = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);

    assign chk.ok       = year_ok && month_ok && day_ok && time_ok;
    assign chk.dim_cur  = dim_cur;
    assign chk.dim_prev = (month == 4'd1) ? 5'd31 : month_days(4'(month - 4'd1), leap_yr);

endmodule

### src/utcl_port_checker.sv
`timescale 1ns / 1ps
`include "utc_to_local_datetime_assert.svh"

module utcl_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_valid_res,
    input logic [12:0] m_local_year,
    input logic [3:0]  m_local_month,
    input logic [4:0]  m_local_day,
    input logic [4:0]  m_local_hour,
    input logic [5:0]  m_local_minute,
    input logic [5:0]  m_local_second,
    input logic [16:0] m_local_seconds_of_day
);

    `UTCL_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_local_seconds_of_day) && $stable(m_valid_res) && $stable(m_local_day), "result changed while stalled")

    `UTCL_ASSERT(a_invalid_zero, m_valid && !m_valid_res |-> m_local_year == 13'd0 && m_local_month == 4'd0 && m_local_day == 5'd0 && m_local_seconds_of_day == 17'd0 && m_local_hour == 5'd0 && m_local_minute == 6'd0 && m_local_second == 6'd0, "invalid result with nonzero fields")

    `UTCL_ASSERT(a_time_split, m_valid && m_valid_res |-> m_local_hour <= 5'd23 && m_local_minute <= 6'd59 && m_local_second <= 6'd59 && m_local_seconds_of_day == 17'(m_local_hour) * 17'd3600 + 17'(m_local_minute) * 17'd60 + 17'(m_local_second), "time fields disagree with seconds of day")

    `UTCL_ASSERT(a_date_range, m_valid && m_valid_res |-> m_local_month >= 4'd1 && m_local_month <= 4'd12 && m_local_day >= 5'd1, "local date out of range")

    `UTCL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind utc_to_local_datetime utcl_port_checker u_port_checker (.*);

### dv/tb_utc_to_local_datetime.sv
`timescale 1ns / 1ps

module tb_utc_to_local_datetime;
    import utcl_pkg::*;

    localparam int PIPE_LAT   = 7;
    localparam int CYCLE_CAP  = 400000;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 100;
    localparam int SIDE_SRC   = 0;
    localparam int SIDE_SINK  = 1;
    localparam bit PREDICT    = 1'b0;
    localparam bit KNOWN      = 1'b1;
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } utc_stamp_t;

    typedef struct packed {
        logic        ok;
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] sod;
    } local_stamp_t;

    typedef struct packed {
        bit           is_cfg;
        logic [1:0]   addr;
        logic [16:0]  data;
        utc_stamp_t   stamp;
        bit           typed;
        local_stamp_t want;
    } plan_row_t;

    localparam local_stamp_t REJECT = '0;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [16:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [11:0] s_utc_year   = '0;
    logic [3:0]  s_utc_month  = '0;
    logic [4:0]  s_utc_day    = '0;
    logic [4:0]  s_utc_hour   = '0;
    logic [5:0]  s_utc_minute = '0;
    logic [5:0]  s_utc_second = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_valid_res;
    logic [12:0] m_local_year;
    logic [3:0]  m_local_month;
    logic [4:0]  m_local_day;
    logic [4:0]  m_local_hour;
    logic [5:0]  m_local_minute;
    logic [5:0]  m_local_second;
    logic [16:0] m_local_seconds_of_day;

    // shadow of the register file
    int zone_offset = -10800;
    int year_lo     = 2024;
    int year_hi     = 2099;

    local_stamp_t pending_local[$];
    plan_row_t    plan_q[$];
    int           n_errors = 0;
    int           cycles   = 0;
    int           wait_left[2] = '{0, 0};
    bit           wait_calm[2] = '{1'b0, 1'b0};

    utc_to_local_datetime u_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_utc_year             (s_utc_year),
        .s_utc_month            (s_utc_month),
        .s_utc_day              (s_utc_day),
        .s_utc_hour             (s_utc_hour),
        .s_utc_minute           (s_utc_minute),
        .s_utc_second           (s_utc_second),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_valid_res            (m_valid_res),
        .m_local_year           (m_local_year),
        .m_local_month          (m_local_month),
        .m_local_day            (m_local_day),
        .m_local_hour           (m_local_hour),
        .m_local_minute         (m_local_minute),
        .m_local_second         (m_local_second),
        .m_local_seconds_of_day (m_local_seconds_of_day)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("** utc_to_local_datetime: FAILED **");
            $finish;
        end
    end

    function automatic bit is_leap(input int y);
        int u;
        u = (y < 0) ? -y : y;
        return ((u % 4 == 0) && (u % 100 != 0)) || (u % 400 == 0);
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic local_stamp_t mk_local(input bit ok, input int y, input int mo,
                                              input int d, input int h, input int mi,
                                              input int s, input int sod);
        local_stamp_t r;
        r.ok     = ok;
        r.year   = 13'(y);
        r.month  = 4'(mo);
        r.day    = 5'(d);
        r.hour   = 5'(h);
        r.minute = 6'(mi);
        r.second = 6'(s);
        r.sod    = 17'(sod);
        return r;
    endfunction

    function automatic local_stamp_t to_local(input utc_stamp_t u);
        int y, m, d, secs;
        bit ok;
        y = int'(u.year);
        m = int'(u.month);
        d = int'(u.day);
        ok = (y >= year_lo) && (y <= year_hi) && (m >= 1) && (m <= 12) &&
             (u.hour <= 5'd23) && (u.minute <= 6'd59) && (u.second <= 6'd59);
        if (ok && (d < 1 || d > days_in_month(y, m)))
            ok = 1'b0;
        if (!ok)
            return REJECT;
        secs = int'(u.hour) * 3600 + int'(u.minute) * 60 + int'(u.second) + zone_offset;
        if (secs < 0) begin
            secs += 86400;
            if (d > 1) begin
                d--;
            end else begin
                if (m > 1) begin
                    m--;
                end else begin
                    m = 12;
                    y--;
                end
                d = days_in_month(y, m);
            end
        end else if (secs >= 86400) begin
            secs -= 86400;
            if (d < days_in_month(y, m)) begin
                d++;
            end else begin
                d = 1;
                if (m < 12) begin
                    m++;
                end else begin
                    m = 1;
                    y++;
                end
            end
        end
        return mk_local(1'b1, y, m, d, secs / 3600, (secs % 3600) / 60, secs % 60, secs);
    endfunction

    // idle stretches come in runs: some runs with no idling at all
    function automatic int draw_wait(input int side);
        if (wait_left[side] == 0) begin
            wait_left[side] = $urandom_range(4, 40);
            wait_calm[side] = ($urandom_range(0, 3) == 0);
        end
        wait_left[side]--;
        return wait_calm[side] ? 0 : int'($urandom_range(0, 11));
    endfunction

    function automatic utc_stamp_t draw_stamp();
        utc_stamp_t s;
        int dim;
        if (year_lo <= year_hi) begin
            case ($urandom_range(0, 5))
                0:       s.year = 12'(year_lo);
                1:       s.year = 12'(year_hi);
                default: s.year = 12'($urandom_range(year_lo, year_hi));
            endcase
        end else begin
            s.year = 12'($urandom);
        end
        s.month = 4'($urandom_range(1, 12));
        dim = days_in_month(int'(s.year), int'(s.month));
        case ($urandom_range(0, 2))
            0:       s.day = 5'd1;
            1:       s.day = 5'(dim);
            default: s.day = 5'($urandom_range(1, dim));
        endcase
        s.hour   = 5'($urandom_range(0, 23));
        s.minute = 6'($urandom_range(0, 59));
        s.second = 6'($urandom_range(0, 59));
        return s;
    endfunction

    function automatic utc_stamp_t break_stamp(input utc_stamp_t s);
        int dim;
        case ($urandom_range(0, 5))
            0: s.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
            1: begin
                dim = days_in_month(int'(s.year), int'(s.month));
                s.day = (dim == 31 || $urandom_range(0, 1)) ? 5'd0
                                                             : 5'($urandom_range(dim + 1, 31));
            end
            2: s.hour   = 5'($urandom_range(24, 31));
            3: s.minute = 6'($urandom_range(60, 63));
            4: s.second = 6'($urandom_range(60, 63));
            default: begin
                if (year_lo > 0)
                    s.year = 12'(year_lo - 1);
                else if (year_hi < 4095)
                    s.year = 12'(year_hi + 1);
            end
        endcase
        return s;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        n_errors++;
    endtask

    task automatic send_stamp(input utc_stamp_t st, input local_stamp_t want);
        int gap;
        gap = draw_wait(SIDE_SRC);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_utc_year   <= st.year;
        s_utc_month  <= st.month;
        s_utc_day    <= st.day;
        s_utc_hour   <= st.hour;
        s_utc_minute <= st.minute;
        s_utc_second <= st.second;
        pending_local.push_back(want);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_local.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [16:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_IDX_OFFSET:   zone_offset = int'($signed(data));
            CFG_IDX_YEAR_MIN: year_lo = int'(data[11:0]);
            CFG_IDX_YEAR_MAX: year_hi = int'(data[11:0]);
            default: ;
        endcase
    endtask

    task automatic plan_cfg(input logic [1:0] addr, input int value);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.data   = 17'(value);
        plan_q.push_back(row);
    endtask

    task automatic plan_stamp(input int y, input int mo, input int d, input int h,
                              input int mi, input int s, input bit typed,
                              input local_stamp_t want);
        plan_row_t row;
        row = '0;
        row.stamp = {12'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)};
        row.typed = typed;
        row.want  = want;
        plan_q.push_back(row);
    endtask

    // result side: per-result stall, then hold ready until a transfer
    initial begin : sink
        int stall;
        forever begin
            stall = draw_wait(SIDE_SINK);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        local_stamp_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_valid_res, m_local_year, m_local_month, m_local_day, m_local_hour,
                   m_local_minute, m_local_second, m_local_seconds_of_day};
            if (pending_local.size() == 0) begin
                flag_error("result transfer with nothing pending");
            end else begin
                want = pending_local.pop_front();
                if (got.ok !== want.ok)
                    flag_error($sformatf("valid_res got %0d want %0d", got.ok, want.ok));
                if (got.year !== want.year)
                    flag_error($sformatf("local_year got %0d want %0d", got.year, want.year));
                if (got.month !== want.month)
                    flag_error($sformatf("local_month got %0d want %0d", got.month,
                                         want.month));
                if (got.day !== want.day)
                    flag_error($sformatf("local_day got %0d want %0d", got.day, want.day));
                if (got.hour !== want.hour)
                    flag_error($sformatf("local_hour got %0d want %0d", got.hour, want.hour));
                if (got.minute !== want.minute)
                    flag_error($sformatf("local_minute got %0d want %0d", got.minute,
                                         want.minute));
                if (got.second !== want.second)
                    flag_error($sformatf("local_second got %0d want %0d", got.second,
                                         want.second));
                if (got.sod !== want.sod)
                    flag_error($sformatf("local_seconds_of_day got %0d want %0d", got.sod,
                                         want.sod));
            end
        end
    end

    initial begin : stim
        int off, lo, hi, hold_at;
        utc_stamp_t st;

        // reset values: offset -3 h, years 2024..2099
        plan_stamp(2024, 1, 1, 0, 0, 0, KNOWN, mk_local(1'b1, 2023, 12, 31, 21, 0, 0, 75600));
        plan_stamp(2099, 12, 31, 23, 59, 59, KNOWN,
                   mk_local(1'b1, 2099, 12, 31, 20, 59, 59, 75599));
        plan_stamp(2023, 6, 15, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2100, 6, 15, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2050, 0, 10, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2050, 13, 10, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2050, 15, 31, 31, 63, 63, KNOWN, REJECT);
        plan_stamp(2050, 5, 0, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2050, 4, 31, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2025, 2, 29, 12, 0, 0, KNOWN, REJECT);
        plan_stamp(2024, 2, 29, 12, 0, 0, PREDICT, REJECT);
        plan_stamp(2050, 6, 15, 24, 0, 0, KNOWN, REJECT);
        plan_stamp(2050, 6, 15, 12, 60, 0, KNOWN, REJECT);
        plan_stamp(2050, 6, 15, 12, 0, 60, KNOWN, REJECT);
        plan_stamp(2024, 3, 1, 1, 0, 0, PREDICT, REJECT);
        // full year range, largest positive offset
        plan_cfg(CFG_IDX_YEAR_MIN, 0);
        plan_cfg(CFG_IDX_YEAR_MAX, 4095);
        plan_cfg(CFG_IDX_OFFSET, 65535);
        plan_stamp(4095, 12, 31, 23, 59, 59, KNOWN,
                   mk_local(1'b1, 4096, 1, 1, 18, 12, 14, 65534));
        plan_stamp(2100, 2, 28, 12, 0, 0, PREDICT, REJECT);
        plan_stamp(2000, 2, 28, 12, 0, 0, PREDICT, REJECT);
        plan_stamp(0, 0, 0, 0, 0, 0, KNOWN, REJECT);
        // most negative offset: year 0 rolls back to year -1
        plan_cfg(CFG_IDX_OFFSET, -65536);
        plan_stamp(0, 1, 1, 0, 0, 0, KNOWN, mk_local(1'b1, 8191, 12, 31, 5, 47, 44, 20864));
        plan_stamp(2400, 3, 1, 10, 0, 0, PREDICT, REJECT);
        plan_stamp(2000, 1, 1, 23, 59, 59, PREDICT, REJECT);
        // unused index must not land anywhere; empty year window
        plan_cfg(CFG_IDX_UNUSED, 'h1ABCD);
        plan_cfg(CFG_IDX_YEAR_MIN, 3000);
        plan_cfg(CFG_IDX_YEAR_MAX, 2000);
        plan_stamp(2500, 6, 15, 12, 0, 0, KNOWN, REJECT);
        plan_cfg(CFG_IDX_YEAR_MIN, 0);
        plan_stamp(2000, 6, 15, 12, 0, 0, PREDICT, REJECT);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan_q[i]) begin
            if (plan_q[i].is_cfg)
                write_reg(plan_q[i].addr, plan_q[i].data);
            else
                send_stamp(plan_q[i].stamp,
                           plan_q[i].typed ? plan_q[i].want : to_local(plan_q[i].stamp));
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0:       off = -65536;
                1:       off = 65535;
                2:       off = int'($urandom_range(0, 131071)) - 65536;
                default: off = int'($urandom_range(0, 100799)) - 50399;
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    lo = 0;
                    hi = 4095;
                end
                1: begin
                    lo = $urandom_range(1, 4095);
                    hi = $urandom_range(0, lo - 1);
                end
                default: begin
                    lo = $urandom_range(0, 3900);
                    hi = lo + int'($urandom_range(0, 195));
                end
            endcase
            write_reg(CFG_IDX_UNUSED, 17'($urandom));
            write_reg(CFG_IDX_OFFSET, 17'(off));
            write_reg(CFG_IDX_YEAR_MIN, 17'(lo));
            write_reg(CFG_IDX_YEAR_MAX, 17'(hi));
            hold_at = $urandom_range(10, PHASE_LEN - 10);
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (k == hold_at)
                    wait_idle();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        st.year   = 12'($urandom);
                        st.month  = 4'($urandom);
                        st.day    = 5'($urandom);
                        st.hour   = 5'($urandom);
                        st.minute = 6'($urandom);
                        st.second = 6'($urandom);
                    end
                    5, 6:    st = break_stamp(draw_stamp());
                    default: st = draw_stamp();
                endcase
                send_stamp(st, to_local(st));
            end
        end

        wait_idle();
        if (n_errors == 0)
            $display("** utc_to_local_datetime: PASSED **");
        else
            $display("** utc_to_local_datetime: FAILED **");
        $finish;
    end

endmodule

### utc_to_local_datetime.f
+incdir+src
src/utcl_pkg.sv
src/utcl_date_check.sv
src/utc_to_local_datetime.sv
src/utcl_port_checker.sv
dv/tb_utc_to_local_datetime.sv
